>>> rtl/lpmt_pkg.sv
// Package for the IPv6 LPM flow-label tagger: beat structs, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
package lpmt_pkg;
    typedef enum logic [1:0] {
        ACT_LABEL   = 2'd0,
        ACT_UNLABEL = 2'd1,
        ACT_INSERT  = 2'd2,
        ACT_DELETE  = 2'd3
    } t_action;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [7:0]  MAX_PREFIX  = 8'd128;
    localparam logic [23:0] NIBBLE_KEEP = 24'hF00000;

    typedef struct packed {
        logic [1:0]  action;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  prefix_length;
        logic [19:0] entry_label;
        logic [23:0] header_bytes;
    } t_in_beat;

    typedef struct packed {
        logic [23:0] header_bytes_out;
        logic        matched;
        logic [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  len;
        logic [19:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } t_state;

    function automatic logic [127:0] prefix_mask(input logic [7:0] len);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++) m[127 - b] = (b < int'(len));
        return m;
    endfunction
endpackage

>>> rtl/lpmt_table.sv
// Entry memory for the LPM table: registered read, single write port.
// Depends on lpmt_pkg.
`timescale 1ns / 1ps
module lpmt_table import lpmt_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);
    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

>>> rtl/ipv6_lpm_flow_label_tagger_unit.sv
// Top level of the IPv6 LPM flow-label tagger: sequencer, valid bits, result register.
// Depends on lpmt_pkg and lpmt_table.
//
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_stall  | t_in_beat
//  out     | out | o_valid / i_stall  | t_out_beat
//
// Label, insert and delete beats scan every entry, one memory read a cycle; the result
// then passes from S_SCAN (which also drains the read pipe) through the write slot
// S_WRITE and the output slot S_OUT, and the next beat is taken back in S_IDLE.
// Unlabel and non-IPv6 label beats skip the scan and go straight to S_OUT.
// Reset clears the valid bits at once; no clearing pass.
// A result held under i_stall does not block the input; a new result waits in S_OUT.
`timescale 1ns / 1ps
module ipv6_lpm_flow_label_tagger_unit import lpmt_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state r_state, n_state;
    t_in_beat r_in;
    logic [127:0] r_key;
    logic [7:0] r_len;
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_rd_idx;
    logic r_rd_ok;
    logic r_hit, r_exact, r_free;
    logic [AW-1:0] r_exact_idx, r_free_idx;
    logic [7:0] r_best_len;
    logic [19:0] r_best_tag;
    t_out_beat r_out, n_out;
    logic r_oval;

    t_entry rd_data, wr_data;
    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0] in_len;
    logic [127:0] msk, kmsk;
    logic e_valid, e_lpm, e_exact;
    logic out_load;

    lpmt_table #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_table (
        .i_clk(i_clk), .i_rd_addr(rd_addr), .o_rd_data(rd_data),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data)
    );

    assign in_len  = (i_data.prefix_length > MAX_PREFIX) ? MAX_PREFIX : i_data.prefix_length;
    assign kmsk    = prefix_mask(in_len);
    assign rd_addr = r_cnt[AW-1:0];
    assign msk     = prefix_mask(rd_data.len);
    assign e_valid = r_rd_ok && r_vld[r_rd_idx];
    assign e_lpm   = e_valid && ((r_key & msk) == {rd_data.hi, rd_data.lo});
    assign e_exact = e_valid && (rd_data.len == r_len) && ({rd_data.hi, rd_data.lo} == r_key);

    assign wr_en   = (r_state == S_WRITE) && r_in.action == ACT_INSERT && (r_exact || r_free);
    assign wr_addr = r_exact ? r_exact_idx : r_free_idx;
    assign wr_data = '{hi: r_key[127:64], lo: r_key[63:0], len: r_len, tag: r_in.entry_label};

    assign out_load = (r_state == S_OUT) && (!r_oval || !i_stall);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && !o_stall) begin
                if (i_data.action == ACT_UNLABEL ||
                    (i_data.action == ACT_LABEL && !i_data.is_ipv6)) n_state = S_OUT;
                else n_state = S_SCAN;
            end
            S_SCAN:  if (!r_rd_ok && r_cnt == CW'(TABLE_ENTRIES)) n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out = '0;
        unique case (t_action'(r_in.action))
            ACT_LABEL: begin
                if (!r_in.is_ipv6) n_out.header_bytes_out = r_in.header_bytes;
                else begin
                    n_out.header_bytes_out = (r_in.header_bytes & NIBBLE_KEEP) |
                        {4'd0, (r_hit ? r_best_tag : 20'd0)};
                    n_out.matched = r_hit;
                end
            end
            ACT_UNLABEL: n_out.header_bytes_out = r_in.is_ipv6 ?
                (r_in.header_bytes & NIBBLE_KEEP) : r_in.header_bytes;
            ACT_INSERT: n_out.status = (r_exact || r_free) ? ST_OK : ST_FULL;
            ACT_DELETE: n_out.status = r_exact ? ST_OK : ST_NOTFOUND;
            default: n_out.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_oval  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_oval <= 1'b1;
                r_out  <= n_out;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            r_rd_ok <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_in   <= i_data;
                    r_len  <= in_len;
                    r_key  <= (i_data.action == ACT_LABEL) ?
                              {i_data.addr_high, i_data.addr_low} :
                              ({i_data.addr_high, i_data.addr_low} & kmsk);
                    r_cnt  <= '0;
                    r_hit  <= 1'b0;
                    r_exact <= 1'b0;
                    r_free <= 1'b0;
                end
                S_SCAN: begin
                    if (r_cnt != CW'(TABLE_ENTRIES)) begin
                        r_rd_ok  <= 1'b1;
                        r_rd_idx <= r_cnt[AW-1:0];
                        r_cnt    <= r_cnt + 1'b1;
                    end
                    if (r_rd_ok) begin
                        if (e_lpm && (!r_hit || rd_data.len > r_best_len)) begin
                            r_hit <= 1'b1;
                            r_best_len <= rd_data.len;
                            r_best_tag <= rd_data.tag;
                        end
                        if (e_exact && !r_exact) begin
                            r_exact <= 1'b1;
                            r_exact_idx <= r_rd_idx;
                        end
                        if (!r_vld[r_rd_idx] && !r_free) begin
                            r_free <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end
                end
                S_WRITE: begin
                    if (wr_en) r_vld[wr_addr] <= 1'b1;
                    if (r_in.action == ACT_DELETE && r_exact) r_vld[r_exact_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("beat accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("result dropped");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !out_load) else $error("result overwritten");
    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_in.action == ACT_INSERT)) else $error("stray table write");
endmodule
